@@ rtl/core/gr4jps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr4jps_pkg
// Shared types and constants of the GR4J production store step core.
// ----------------------------------------------------------------------------
package gr4jps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QB        = 30;

    localparam logic [31:0] CAP_RESET = 32'(350 << FRAC_BITS);

    localparam logic [33:0] ONE_Q    = 34'd1 << QB;
    localparam logic [33:0] TWO_Q    = 34'd2 << QB;
    localparam logic [33:0] FIVE_Q   = 34'd5 << QB;
    localparam logic [33:0] LN2_Q    = 34'd744261118;
    localparam logic [63:0] TANH_SAT = 64'd20 << QB;
    // ceil(2^35 / 9): exact floor(n / 9) for any n up to 2^32 after >> 35
    localparam logic [33:0] RECIP9   = 34'd3817748708;

    localparam logic [3:0] TAYLOR_LAST = 4'd12;
    localparam logic [2:0] NEWTON_LAST = 3'd5;
    localparam logic [5:0] EXP_K_MAX   = 6'd62;
    localparam logic [5:0] DIV_LAST    = 6'd63;

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0,
        REG_INIT     = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] net;
        logic        wet;
        logic        first;
    } job_t;

    typedef struct packed {
        logic [31:0] capacity;
        logic [31:0] init_store;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [33:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/core/gr4jps_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr4jps_front
// Accept steps and split them into net rain or net evaporation jobs.
// ----------------------------------------------------------------------------
module gr4jps_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        rainfall,
    input  logic [31:0]        potential_evap,
    input  logic               first_step,
    input  logic               q_full,
    output logic               q_push,
    output gr4jps_pkg::job_t   q_job
);
    import gr4jps_pkg::*;

    logic wet;

    assign wet      = rainfall > potential_evap;
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_job.wet   = wet;
        q_job.first = first_step;
        if (wet)
        begin
            q_job.net = rainfall - potential_evap;
        end
        else
        begin
            q_job.net = potential_evap - rainfall;
        end
    end

endmodule

@@ rtl/core/gr4jps_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr4jps_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module gr4jps_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gr4jps_pkg::job_t   push_job,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output gr4jps_pkg::job_t   head_job
);
    import gr4jps_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/core/gr4jps_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr4jps_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module gr4jps_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gr4jps_pkg::div_req_t   req,
    output gr4jps_pkg::div_rsp_t   rsp
);
    import gr4jps_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [63:0] quo_reg;
    logic [33:0] dsr_reg;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        fits;

    assign trial = {rem_reg, quo_reg[63]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            rem_reg  <= 34'd0;
            quo_reg  <= 64'd0;
            dsr_reg  <= 34'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                rem_reg  <= 34'd0;
                quo_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                rem_reg <= fits ? diff[33:0] : trial[33:0];
                quo_reg <= {quo_reg[62:0], fits};
                if (cnt_reg == DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/core/gr4jps_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr4jps_back
// Sequencer that runs one step of the store update over a shared multiplier
// and the shared divider, and holds the store level and the result register.
// ----------------------------------------------------------------------------
module gr4jps_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gr4jps_pkg::cfg_t       cfg,
    input  logic                   job_valid,
    input  gr4jps_pkg::job_t       job,
    output logic                   job_pop,
    output gr4jps_pkg::div_req_t   div_req,
    input  gr4jps_pkg::div_rsp_t   div_rsp,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [31:0]            effective_rain,
    output logic [31:0]            store_level,
    output logic [31:0]            actual_evap
);
    import gr4jps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_R_DIV, ST_X_DIV, ST_K_SUB, ST_RR, ST_T_MUL, ST_T_DIV,
        ST_EXP_END, ST_TANH_DIV, ST_A1, ST_A2, ST_DEN, ST_FRAC_DIV, ST_PS,
        ST_S1, ST_R1_DIV, ST_Q_MUL, ST_Q2, ST_Q4, ST_N_Y2, ST_N_Y4,
        ST_N_VY4, ST_N_Y, ST_PERC, ST_OUT
    } state_t;

    state_t             state_reg;
    logic               issued_reg;
    logic [31:0]        store_reg;
    logic [31:0]        cap_reg;
    logic [31:0]        s_reg;
    logic [31:0]        net_reg;
    logic               wet_reg;
    logic [33:0]        r_reg;
    logic [36:0]        ey_reg;
    logic [5:0]         k_reg;
    logic [33:0]        rr_reg;
    logic [33:0]        term_reg;
    logic [33:0]        tp_reg;
    logic signed [35:0] sum_reg;
    logic [3:0]         i_reg;
    logic [33:0]        e_reg;
    logic [33:0]        t_reg;
    logic [33:0]        tmp_reg;
    logic [33:0]        a_reg;
    logic [33:0]        den_reg;
    logic [33:0]        frac_reg;
    logic [31:0]        ps_reg;
    logic [31:0]        es_reg;
    logic [31:0]        s1_reg;
    logic [33:0]        r1_reg;
    logic [33:0]        q_reg;
    logic [33:0]        q2_reg;
    logic [33:0]        v_reg;
    logic [33:0]        ny_reg;
    logic [33:0]        ny2_reg;
    logic [33:0]        ny4_reg;
    logic [33:0]        vy4_reg;
    logic [2:0]         n_cnt_reg;
    logic [31:0]        perc_reg;
    logic               out_valid_reg;
    logic [31:0]        eff_out_reg;
    logic [31:0]        lvl_out_reg;
    logic [31:0]        evap_out_reg;

    logic [33:0] mul_a;
    logic [33:0] mul_b;
    logic [67:0] prod;
    logic [33:0] prod_q;
    logic [33:0] y_cap;
    logic [31:0] cap_next;
    logic [31:0] s_pick;
    logic [31:0] s_next;
    logic [31:0] pn;
    logic [31:0] room;
    logic [35:0] sum_u;
    logic [35:0] e_shift;
    logic [33:0] newton_f;
    logic [31:0] s2;
    logic [32:0] u_sum;
    logic        can_load;
    logic        out_load;
    logic        div_go;

    assign prod     = mul_a * mul_b;
    assign prod_q   = prod[63:30];
    assign y_cap    = (ny_reg > ONE_Q) ? ONE_Q : ny_reg;
    assign cap_next = (cfg.capacity == 32'd0) ? 32'd1 : cfg.capacity;
    assign s_pick   = job.first ? cfg.init_store : store_reg;
    assign s_next   = (s_pick > cap_next) ? cap_next : s_pick;
    assign pn       = wet_reg ? net_reg : 32'd0;
    assign room     = cap_reg - s_reg;
    assign sum_u    = $unsigned(sum_reg);
    assign e_shift  = sum_u >> k_reg;
    assign newton_f = (vy4_reg >= FIVE_Q) ? 34'd0 : (FIVE_Q - vy4_reg);
    assign s2       = s1_reg - perc_reg;
    assign u_sum    = {1'b0, perc_reg} + {1'b0, pn - ps_reg};
    assign can_load = !out_valid_reg || out_ready;
    assign out_load = (state_reg == ST_OUT) && can_load;
    assign div_go   = !issued_reg;

    assign job_pop        = (state_reg == ST_IDLE) && job_valid;
    assign out_valid      = out_valid_reg;
    assign effective_rain = eff_out_reg;
    assign store_level    = lvl_out_reg;
    assign actual_evap    = evap_out_reg;

    // Operand selection for the shared multiplier and divider
    always_comb
    begin
        mul_a            = 34'd0;
        mul_b            = 34'd0;
        div_req.start    = 1'b0;
        div_req.dividend = 64'd0;
        div_req.divisor  = 34'd1;
        unique case (state_reg)
            ST_R_DIV:
            begin
                div_req.start    = div_go;
                div_req.dividend = {2'b00, s_reg, 30'd0};
                div_req.divisor  = {2'b00, cap_reg};
            end
            ST_X_DIV:
            begin
                div_req.start    = div_go;
                div_req.dividend = {2'b00, net_reg, 30'd0};
                div_req.divisor  = {2'b00, cap_reg};
            end
            ST_T_MUL:
            begin
                mul_a = term_reg;
                mul_b = rr_reg;
            end
            ST_T_DIV:
            begin
                div_req.start    = div_go;
                div_req.dividend = {30'd0, tp_reg};
                div_req.divisor  = {30'd0, i_reg};
            end
            ST_TANH_DIV:
            begin
                div_req.start    = div_go;
                div_req.dividend = {ONE_Q - e_reg, 30'd0};
                div_req.divisor  = ONE_Q + e_reg;
            end
            ST_A1:
            begin
                mul_a = wet_reg ? r_reg : (ONE_Q - r_reg);
                mul_b = wet_reg ? r_reg : t_reg;
            end
            ST_A2:
            begin
                mul_a = wet_reg ? (ONE_Q - tmp_reg) : (TWO_Q - r_reg);
                mul_b = t_reg;
            end
            ST_DEN:
            begin
                mul_a = r_reg;
                mul_b = t_reg;
            end
            ST_FRAC_DIV:
            begin
                div_req.start    = div_go;
                div_req.dividend = {a_reg, 30'd0};
                div_req.divisor  = den_reg;
            end
            ST_PS:
            begin
                mul_a = wet_reg ? {2'b00, cap_reg} : {2'b00, s_reg};
                mul_b = frac_reg;
            end
            ST_R1_DIV:
            begin
                div_req.start    = div_go;
                div_req.dividend = {2'b00, s1_reg, 30'd0};
                div_req.divisor  = {2'b00, cap_reg};
            end
            ST_Q_MUL:
            begin
                // 4 * r1 / 9 by reciprocal multiplication; r1 never exceeds ONE
                mul_a = {r1_reg[31:0], 2'b00};
                mul_b = RECIP9;
            end
            ST_Q2:
            begin
                mul_a = q_reg;
                mul_b = q_reg;
            end
            ST_Q4:
            begin
                mul_a = q2_reg;
                mul_b = q2_reg;
            end
            ST_N_Y2:
            begin
                mul_a = ny_reg;
                mul_b = ny_reg;
            end
            ST_N_Y4:
            begin
                mul_a = ny2_reg;
                mul_b = ny2_reg;
            end
            ST_N_VY4:
            begin
                mul_a = v_reg;
                mul_b = ny4_reg;
            end
            ST_N_Y:
            begin
                mul_a = ny_reg;
                mul_b = newton_f;
            end
            ST_PERC:
            begin
                mul_a = {2'b00, s1_reg};
                mul_b = ONE_Q - y_cap;
            end
            default:
            begin
                mul_a = 34'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            store_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
            eff_out_reg   <= 32'd0;
            lvl_out_reg   <= 32'd0;
            evap_out_reg  <= 32'd0;
            cap_reg       <= 32'd1;
            s_reg         <= 32'd0;
            net_reg       <= 32'd0;
            wet_reg       <= 1'b0;
            r_reg         <= 34'd0;
            ey_reg        <= 37'd0;
            k_reg         <= 6'd0;
            rr_reg        <= 34'd0;
            term_reg      <= 34'd0;
            tp_reg        <= 34'd0;
            sum_reg       <= 36'sd0;
            i_reg         <= 4'd1;
            e_reg         <= 34'd0;
            t_reg         <= 34'd0;
            tmp_reg       <= 34'd0;
            a_reg         <= 34'd0;
            den_reg       <= 34'd0;
            frac_reg      <= 34'd0;
            ps_reg        <= 32'd0;
            es_reg        <= 32'd0;
            s1_reg        <= 32'd0;
            r1_reg        <= 34'd0;
            q_reg         <= 34'd0;
            q2_reg        <= 34'd0;
            v_reg         <= 34'd0;
            ny_reg        <= 34'd0;
            ny2_reg       <= 34'd0;
            ny4_reg       <= 34'd0;
            vy4_reg       <= 34'd0;
            n_cnt_reg     <= 3'd0;
            perc_reg      <= 32'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            if (div_rsp.done)
            begin
                issued_reg <= 1'b0;
            end
            else if (div_req.start)
            begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        cap_reg   <= cap_next;
                        s_reg     <= s_next;
                        net_reg   <= job.net;
                        wet_reg   <= job.wet;
                        state_reg <= ST_R_DIV;
                    end
                end
                ST_R_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        r_reg     <= div_rsp.quotient[33:0];
                        state_reg <= ST_X_DIV;
                    end
                end
                ST_X_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.quotient >= TANH_SAT)
                        begin
                            t_reg     <= ONE_Q;
                            state_reg <= ST_A1;
                        end
                        else
                        begin
                            ey_reg    <= {div_rsp.quotient[35:0], 1'b0};
                            k_reg     <= 6'd0;
                            state_reg <= ST_K_SUB;
                        end
                    end
                end
                ST_K_SUB:
                begin
                    // Strip whole ln2 steps; what is left is the reduced argument
                    if (ey_reg >= {3'b000, LN2_Q})
                    begin
                        ey_reg <= ey_reg - {3'b000, LN2_Q};
                        k_reg  <= k_reg + 6'd1;
                    end
                    else
                    begin
                        state_reg <= ST_RR;
                    end
                end
                ST_RR:
                begin
                    rr_reg    <= ey_reg[33:0];
                    term_reg  <= ONE_Q;
                    sum_reg   <= $signed({2'b00, ONE_Q});
                    i_reg     <= 4'd1;
                    state_reg <= ST_T_MUL;
                end
                ST_T_MUL:
                begin
                    tp_reg    <= prod_q;
                    state_reg <= ST_T_DIV;
                end
                ST_T_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        term_reg <= div_rsp.quotient[33:0];
                        if (i_reg[0])
                        begin
                            sum_reg <= sum_reg - $signed({2'b00, div_rsp.quotient[33:0]});
                        end
                        else
                        begin
                            sum_reg <= sum_reg + $signed({2'b00, div_rsp.quotient[33:0]});
                        end
                        if (i_reg == TAYLOR_LAST)
                        begin
                            state_reg <= ST_EXP_END;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 4'd1;
                            state_reg <= ST_T_MUL;
                        end
                    end
                end
                ST_EXP_END:
                begin
                    if (sum_reg[35] || (k_reg >= EXP_K_MAX))
                    begin
                        e_reg <= 34'd0;
                    end
                    else
                    begin
                        e_reg <= e_shift[33:0];
                    end
                    state_reg <= ST_TANH_DIV;
                end
                ST_TANH_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        t_reg     <= div_rsp.quotient[33:0];
                        state_reg <= ST_A1;
                    end
                end
                ST_A1:
                begin
                    tmp_reg   <= prod_q;
                    state_reg <= ST_A2;
                end
                ST_A2:
                begin
                    a_reg     <= prod_q;
                    state_reg <= ST_DEN;
                end
                ST_DEN:
                begin
                    den_reg   <= ONE_Q + (wet_reg ? prod_q : tmp_reg);
                    state_reg <= ST_FRAC_DIV;
                end
                ST_FRAC_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        frac_reg  <= div_rsp.quotient[33:0];
                        state_reg <= ST_PS;
                    end
                end
                ST_PS:
                begin
                    if (wet_reg)
                    begin
                        es_reg <= 32'd0;
                        // clamp to the net rain and to the free room
                        if ((prod_q <= {2'b00, net_reg}) && (prod_q <= {2'b00, room}))
                        begin
                            ps_reg <= prod_q[31:0];
                        end
                        else if (net_reg < room)
                        begin
                            ps_reg <= net_reg;
                        end
                        else
                        begin
                            ps_reg <= room;
                        end
                    end
                    else
                    begin
                        ps_reg <= 32'd0;
                        es_reg <= (prod_q > {2'b00, s_reg}) ? s_reg : prod_q[31:0];
                    end
                    state_reg <= ST_S1;
                end
                ST_S1:
                begin
                    s1_reg    <= s_reg - es_reg + ps_reg;
                    state_reg <= ST_R1_DIV;
                end
                ST_R1_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        r1_reg    <= div_rsp.quotient[33:0];
                        state_reg <= ST_Q_MUL;
                    end
                end
                ST_Q_MUL:
                begin
                    q_reg     <= {1'b0, prod[67:35]};
                    state_reg <= ST_Q2;
                end
                ST_Q2:
                begin
                    q2_reg    <= prod_q;
                    state_reg <= ST_Q4;
                end
                ST_Q4:
                begin
                    v_reg     <= ONE_Q + prod_q;
                    ny_reg    <= ONE_Q;
                    n_cnt_reg <= 3'd0;
                    state_reg <= ST_N_Y2;
                end
                ST_N_Y2:
                begin
                    ny2_reg   <= prod_q;
                    state_reg <= ST_N_Y4;
                end
                ST_N_Y4:
                begin
                    ny4_reg   <= prod_q;
                    state_reg <= ST_N_VY4;
                end
                ST_N_VY4:
                begin
                    vy4_reg   <= prod_q;
                    state_reg <= ST_N_Y;
                end
                ST_N_Y:
                begin
                    ny_reg <= prod[65:32];
                    if (n_cnt_reg == NEWTON_LAST)
                    begin
                        state_reg <= ST_PERC;
                    end
                    else
                    begin
                        n_cnt_reg <= n_cnt_reg + 3'd1;
                        state_reg <= ST_N_Y2;
                    end
                end
                ST_PERC:
                begin
                    perc_reg  <= (prod_q > {2'b00, s1_reg}) ? s1_reg : prod_q[31:0];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (can_load)
                    begin
                        store_reg     <= s2;
                        lvl_out_reg   <= s2;
                        evap_out_reg  <= es_reg;
                        eff_out_reg   <= u_sum[32] ? 32'hFFFF_FFFF : u_sum[31:0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/gr4j_production_store_step_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gr4j_production_store_step_core
// GR4J production store: one rainfall / evaporation step per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one time step: rainfall,
//   potential_evap (unsigned Q16.16 mm) and first_step. Output channel
//   (out_valid / out_ready) returns effective_rain, store_level and
//   actual_evap for that step, in order, one result per item.
//   The APB port sets store_capacity (0x0) and initial_store (0x4); write
//   them only while the core is idle.
//   Per item the bit-serial divider runs up to 17 divisions, fewer when
//   tanh saturates, plus multiply, ln2 reduction and control steps.
//   One item runs at a time: the back end takes the next item only after
//   the last one has been handed to the result register.
//   A two-entry queue holds items accepted while the back end is busy, and
//   a result register lets the next item start while a result waits.
//   If out_ready stays low, the queue fills and in_ready drops.
//   Reset clears the store level to 0, capacity to 350 mm, initial store
//   to 0, and empties the queue and result register.
// ----------------------------------------------------------------------------
module gr4j_production_store_step_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] rainfall,
    input  logic [31:0] potential_evap,
    input  logic        first_step,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] effective_rain,
    output logic [31:0] store_level,
    output logic [31:0] actual_evap
);
    import gr4jps_pkg::*;

    logic [31:0] cap_cfg_reg;
    logic [31:0] init_cfg_reg;
    cfg_t        cfg;
    reg_idx_t    reg_idx;
    logic        wr_en;
    logic        q_full;
    logic        q_push;
    job_t        q_in_job;
    logic        q_pop;
    logic        q_valid;
    job_t        q_head;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // Register file: word address selects the register
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (reg_idx)
            REG_CAPACITY: prdata = cap_cfg_reg;
            REG_INIT:     prdata = init_cfg_reg;
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg  <= CAP_RESET;
            init_cfg_reg <= 32'd0;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_CAPACITY)
            begin
                cap_cfg_reg <= pwdata;
            end
            else
            begin
                init_cfg_reg <= pwdata;
            end
        end
    end

    assign cfg.capacity   = cap_cfg_reg;
    assign cfg.init_store = init_cfg_reg;

    // Front: accept and classify steps
    gr4jps_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rainfall       (rainfall),
        .potential_evap (potential_evap),
        .first_step     (first_step),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (q_in_job)
    );

    // Decouple front from back
    gr4jps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_in_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    // Shared divider for all ratios, tanh and Taylor terms
    gr4jps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back: run the store update and hold the result
    gr4jps_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .job_valid      (q_valid),
        .job            (q_head),
        .job_pop        (q_pop),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .effective_rain (effective_rain),
        .store_level    (store_level),
        .actual_evap    (actual_evap)
    );

endmodule
